@@ src/gbbd_pkg.sv @@
// Shared types and constants of the gradient box blend and dither pixel block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gbbd_pkg;

  // Default coordinate width
  localparam int unsigned CoordBitsDef = 12;

  // Corner color and configuration word widths
  localparam int unsigned ColorBits = 32;
  localparam int unsigned LayoutBits = 27;
  localparam int unsigned CfgIdxBits = 3;

  // Pixel depth codes
  typedef enum logic [1:0] {
    DEPTH_16 = 2'd0,
    DEPTH_24 = 2'd1,
    DEPTH_32 = 2'd2,
    DEPTH_32_ALT = 2'd3
  } depth_e;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_COLOR_UL = 3'd0,
    CFG_COLOR_UR = 3'd1,
    CFG_COLOR_LL = 3'd2,
    CFG_COLOR_LR = 3'd3,
    CFG_BOX_W    = 3'd4,
    CFG_BOX_H    = 3'd5,
    CFG_DEPTH    = 3'd6,
    CFG_LAYOUT   = 3'd7
  } cfg_idx_e;

  // Sideband that travels beside the interpolation pipeline
  typedef struct packed {
    logic [31:0] dst;
    logic        x_odd;
    logic        y_odd;
  } side_t;

endpackage

`default_nettype wire

@@ src/gradient_box_blend_dither_pixel.sv @@
// Top level of the gradient box pixel block: configuration registers,
// stream handshake, blend, dither and pack. Depends on gbbd_pkg, gbbd_interp.
`timescale 1ns / 1ps
`default_nettype none

// One pixel enters per clock while the output is not stalled. The
// interpolation (products, sums, weighting and an 8-stage divider by
// width*height) is followed by one blend stage and one dither/pack stage
// whose register drives the output. The whole pipeline advances whenever
// the output register is empty or taken, so ready follows the downstream
// ready in the same cycle. Configuration must be written only while the
// pipeline holds no pixel; the block itself does not enforce this.
// s_axis_tdata_i: col_offset, row_offset, screen_x_odd, screen_y_odd,
// dest_pixel from bit 0 up, zero-padded to whole bytes.
module gradient_box_blend_dither_pixel #(
  parameter int unsigned COORD_BITS = gbbd_pkg::CoordBitsDef,
  localparam int unsigned InBits = ((2*COORD_BITS + 34 + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [gbbd_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [31:0]           cfg_data_i,
  // input stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [InBits-1:0]     s_axis_tdata_i,  // col, row, x_odd, y_odd, dst
  // output stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [31:0]                m_axis_tdata_o   // pixel_out
);
  import gbbd_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned Lat = 12;

  // Configuration registers
  logic [31:0]         ul_q, ur_q, ll_q, lr_q;
  logic [C-1:0]        bw_q, bh_q;
  logic [1:0]          depth_q;
  logic [LayoutBits-1:0] layout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q     <= '0;
      ur_q     <= '0;
      ll_q     <= '0;
      lr_q     <= '0;
      bw_q     <= {{(C-1){1'b0}}, 1'b1};
      bh_q     <= {{(C-1){1'b0}}, 1'b1};
      depth_q  <= DEPTH_16;
      layout_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COLOR_UL: ul_q     <= cfg_data_i;
        CFG_COLOR_UR: ur_q     <= cfg_data_i;
        CFG_COLOR_LL: ll_q     <= cfg_data_i;
        CFG_COLOR_LR: lr_q     <= cfg_data_i;
        CFG_BOX_W:    bw_q     <= cfg_data_i[C-1:0];
        CFG_BOX_H:    bh_q     <= cfg_data_i[C-1:0];
        CFG_DEPTH:    depth_q  <= cfg_data_i[1:0];
        CFG_LAYOUT:   layout_q <= cfg_data_i[LayoutBits-1:0];
        default: ;
      endcase
    end
  end

  // Zero width or height counts as one
  logic [C-1:0] w_eff, h_eff;
  assign w_eff = (bw_q == '0) ? {{(C-1){1'b0}}, 1'b1} : bw_q;
  assign h_eff = (bh_q == '0) ? {{(C-1){1'b0}}, 1'b1} : bh_q;

  // Input fields
  logic [C-1:0] in_col, in_row;
  side_t        in_side;
  assign in_col        = s_axis_tdata_i[C-1:0];
  assign in_row        = s_axis_tdata_i[2*C-1:C];
  assign in_side.x_odd = s_axis_tdata_i[2*C];
  assign in_side.y_odd = s_axis_tdata_i[2*C+1];
  assign in_side.dst   = s_axis_tdata_i[2*C+33:2*C+2];

  // Global advance: move when the output register is free or taken
  logic            adv;
  logic [Lat+2:1]  vld_q;
  assign adv             = !vld_q[Lat+2] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[Lat+2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat+1:1], s_axis_tvalid_i};
    end
  end

  // Carry sideband along the interpolation stages
  side_t side_q [1:Lat];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[1] <= in_side;
      for (int i = 2; i <= Lat; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Four interpolation lanes: r, g, b, a
  logic [7:0] lane_val [0:3];
  for (genvar c = 0; c < 4; c++) begin : g_lane
    localparam int unsigned Sh = 24 - 8*c;
    gbbd_interp #(.COORD_BITS(C)) u_interp (
      .clk_i (clk_i),
      .en_i  (adv),
      .ul_i  (ul_q[Sh +: 8]),
      .ur_i  (ur_q[Sh +: 8]),
      .ll_i  (ll_q[Sh +: 8]),
      .lr_i  (lr_q[Sh +: 8]),
      .w_i   (w_eff),
      .h_i   (h_eff),
      .col_i (in_col),
      .row_i (in_row),
      .val_o (lane_val[c])
    );
  end

  // Channel layout: offsets, and lengths capped at eight
  logic [4:0] ch_off [0:2];
  logic [3:0] ch_len [0:2];
  for (genvar c = 0; c < 3; c++) begin : g_layout
    logic [3:0] raw_len;
    assign ch_off[c] = layout_q[5*c +: 5];
    assign raw_len   = layout_q[15 + 4*c +: 4];
    assign ch_len[c] = (raw_len > 4'd8) ? 4'd8 : raw_len;
  end

  // Framebuffer pixel cut to the depth
  logic [31:0] dst_m;
  always_comb begin
    case (depth_e'(depth_q))
      DEPTH_16: dst_m = {16'h0000, side_q[Lat].dst[15:0]};
      DEPTH_24: dst_m = {8'h00, side_q[Lat].dst[23:0]};
      default:  dst_m = side_q[Lat].dst;
    endcase
  end

  // Stage 13: blend products
  logic [15:0] bl_q  [0:2];
  logic [7:0]  src_q [0:2];
  logic        opaque_q, xo_q, yo_q;

  for (genvar c = 0; c < 3; c++) begin : g_blend
    logic [31:0] ext;
    logic [8:0]  mask;
    logic [7:0]  field, dv;
    logic [15:0] sum;
    assign ext   = dst_m >> ch_off[c];
    assign mask  = (9'h001 << ch_len[c]) - 9'h001;
    assign field = ext[7:0] & mask[7:0];
    assign dv    = field << (4'd8 - ch_len[c]);
    assign sum   = dv * (8'hff - lane_val[3]) + lane_val[c] * lane_val[3];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        bl_q[c]  <= sum;
        src_q[c] <= lane_val[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      opaque_q <= (lane_val[3] == 8'hff);
      xo_q     <= side_q[Lat].x_odd;
      yo_q     <= side_q[Lat].y_odd;
    end
  end

  // Stage 14: divide by 255, dither, cut and pack
  logic [1:0] dith;
  always_comb begin
    case ({yo_q, xo_q})
      2'b00:   dith = 2'd3;
      2'b01:   dith = 2'd0;
      2'b10:   dith = 2'd1;
      default: dith = 2'd2;
    endcase
  end

  logic [31:0] part [0:2];
  for (genvar c = 0; c < 3; c++) begin : g_pack
    logic [16:0] q255;
    logic [7:0]  mixed, cut;
    logic [9:0]  dsum;
    logic [7:0]  clamped;
    assign q255  = {1'b0, bl_q[c]} + 17'd1 + {9'd0, bl_q[c][15:8]};
    assign mixed = opaque_q ? src_q[c] : q255[15:8];
    // green gets the plain offset, red and blue twice plus one
    assign dsum  = (c == 1) ? ({2'b00, mixed} + {8'd0, dith})
                            : ({2'b00, mixed} + {7'd0, dith, 1'b1});
    assign clamped = (depth_e'(depth_q) != DEPTH_16) ? mixed
                   : ((dsum > 10'd255) ? 8'hff : dsum[7:0]);
    assign cut     = clamped >> (4'd8 - ch_len[c]);
    assign part[c] = {24'h000000, cut} << ch_off[c];
  end

  logic [31:0] pix;
  always_comb begin
    pix = part[0] | part[1] | part[2];
    case (depth_e'(depth_q))
      DEPTH_16: pix = {16'h0000, pix[15:0]};
      DEPTH_24: pix = {8'h00, pix[23:0]};
      default:  pix = pix;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata_o <= pix;
    end
  end

endmodule

`default_nettype wire

@@ src/gbbd_interp.sv @@
// One channel of the bilinear gradient: products, weighted sum and an
// 8-stage restoring divider by width*height, saturated to 0..255.
// Depends on gbbd_pkg. All stages advance only while en_i is high.
`timescale 1ns / 1ps
`default_nettype none

module gbbd_interp #(
  parameter int unsigned COORD_BITS = gbbd_pkg::CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [7:0]            ul_i,
  input  wire logic [7:0]            ur_i,
  input  wire logic [7:0]            ll_i,
  input  wire logic [7:0]            lr_i,
  input  wire logic [COORD_BITS-1:0] w_i,
  input  wire logic [COORD_BITS-1:0] h_i,
  input  wire logic [COORD_BITS-1:0] col_i,
  input  wire logic [COORD_BITS-1:0] row_i,
  output logic      [7:0]            val_o
);
  import gbbd_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned RW = 2*C + 13;   // non-negative numerator width
  localparam int unsigned NW = 2*C + 14;   // signed numerator width
  localparam int unsigned DW = 2*C;        // divisor width

  // Stage 1: corner products
  logic signed [8:0]   du, dl;
  logic        [C+7:0] ulw_q, llw_q;
  logic signed [C+9:0] pcu_d, pcl_d, pcu_q, pcl_q;
  logic signed [C+1:0] t1_d, t1_q, t1b_q;
  logic        [C-1:0] row_q, rowb_q;
  logic        [DW-1:0] dd1_q, dd2_q, dd3_q;

  assign du    = $signed({1'b0, ur_i}) - $signed({1'b0, ul_i});
  assign dl    = $signed({1'b0, lr_i}) - $signed({1'b0, ll_i});
  assign pcu_d = $signed({1'b0, col_i}) * du;
  assign pcl_d = $signed({1'b0, col_i}) * dl;
  assign t1_d  = $signed({2'b00, h_i}) - $signed({2'b00, row_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ulw_q <= ul_i * w_i;
      llw_q <= ll_i * w_i;
      pcu_q <= pcu_d;
      pcl_q <= pcl_d;
      t1_q  <= t1_d;
      row_q <= row_i;
      dd1_q <= w_i * h_i;
    end
  end

  // Stage 2: edge sums
  logic signed [C+10:0] sa_q, sb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= {3'b000, ulw_q} + {pcu_q[C+9], pcu_q};
      sb_q   <= {3'b000, llw_q} + {pcl_q[C+9], pcl_q};
      t1b_q  <= t1_q;
      rowb_q <= row_q;
      dd2_q  <= dd1_q;
    end
  end

  // Stage 3: vertical weights
  logic signed [RW-1:0] m1_d, m2_d, m1_q, m2_q;

  assign m1_d = t1b_q * sa_q;
  assign m2_d = $signed({1'b0, rowb_q}) * sb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      dd3_q <= dd2_q;
    end
  end

  // Stage 4: numerator, sign and overflow flags
  logic [NW-1:0] num_d;
  logic          neg_d, sat_d;

  assign num_d = {m1_q[RW-1], m1_q} + {m2_q[RW-1], m2_q};
  assign neg_d = num_d[NW-1];
  assign sat_d = !neg_d && (num_d[RW-1:0] >= {{(RW-DW-8){1'b0}}, dd3_q, 8'h00});

  logic [RW-1:0] rem_q [0:8];
  logic [7:0]    quo_q [0:8];
  logic [DW-1:0] div_q [0:8];
  logic          neg_q [0:8];
  logic          sat_q [0:8];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_d[RW-1:0];
      quo_q[0] <= 8'h00;
      div_q[0] <= dd3_q;
      neg_q[0] <= neg_d;
      sat_q[0] <= sat_d;
    end
  end

  // Stages 5..12: one quotient bit per stage, high bit first
  for (genvar i = 0; i < 8; i++) begin : g_div
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = {{(RW-DW){1'b0}}, div_q[i]} << (7 - i);
    assign ge    = rem_q[i] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? (rem_q[i] - trial) : rem_q[i];
        quo_q[i+1] <= quo_q[i] | ({7'd0, ge} << (7 - i));
        div_q[i+1] <= div_q[i];
        neg_q[i+1] <= neg_q[i];
        sat_q[i+1] <= sat_q[i];
      end
    end
  end

  // Saturate outside the box
  assign val_o = neg_q[8] ? 8'h00 : (sat_q[8] ? 8'hff : quo_q[8]);

endmodule

`default_nettype wire
